// ----- hdl/base64_chunked_encoder_core_assert.svh -----
// Assertion macros for the base64 chunked encoder.
// Included by the top level; needs aclk and aresetn in scope.
`ifndef BASE64_CHUNKED_ENCODER_CORE_ASSERT_SVH
`define BASE64_CHUNKED_ENCODER_CORE_ASSERT_SVH

// Condition must hold in the same cycle
`define B64CE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the following cycle
`define B64CE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/b64ce_pkg.sv -----
// Package for the base64 chunked encoder: widths, character codes and the
// 6-bit to ASCII alphabet mapping. No dependencies.
package b64ce_pkg;

    localparam int ACC_W     = 14;
    localparam int CHUNK_W   = 10;
    localparam int MAX_CHARS = 6;
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 10'd620;
    localparam logic [7:0]         PAD_CHAR    = 8'h3D;
    localparam logic [7:0]         SEP_CHAR    = 8'h00;

    // A-Z a-z 0-9 + - alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        c = {2'b00, v};
        priority if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd71 + {2'b00, v};
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2D;
        end
        return c;
    endfunction

endpackage

// ----- hdl/base64_chunked_encoder_core.sv -----
// Base64 (A-Z a-z 0-9 + - alphabet) encoder with chunk separators and '=' padding.
// Depends on b64ce_pkg and base64_chunked_encoder_core_assert.svh.
//
// Usage:
//   s_ channel: one raw byte per beat (s_tdata), s_tlast marks the final
//   byte of a stream. m_ channel: one output byte per beat, either an
//   alphabet character, a '=' pad, or a 0x00 chunk separator; m_tlast is
//   set on the final output beat produced by each input byte.
//   cfg_ channel: chunk length in characters, always ready; write it only
//   while the encoder is idle.
// Timing: an input byte produces one to eight output beats (up to four
//   characters, each possibly preceded by a separator). The characters
//   wait in the item register and pass into the output register that drives
//   m_; the output port delivers one beat per cycle while m_tready is high.
//   The next byte is accepted in the cycle the previous byte's last result
//   enters the output register.
// Reset: aresetn low for one clock clears the stream state and chunk count
//   and sets the chunk length to 620. Bytes after a final byte start a new
//   stream.
// Stall: m_tready low holds the output register; the item register fills
//   and s_tready drops until output moves again.
module base64_chunked_encoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // last_byte
    // encoded stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_char
    output logic                          m_tlast,   // end_of_output
    // chunk length register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [b64ce_pkg::CHUNK_W-1:0] cfg_data
);

    // stream state
    logic [b64ce_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [2:0]                    pend_reg, pend_next;
    logic [1:0]                    phase_reg, phase_next;
    logic [b64ce_pkg::CHUNK_W-1:0] len_reg;

    // item register: character list of one input byte
    logic                          a_valid_reg, a_valid_next;
    logic [7:0]                    a_char_reg [b64ce_pkg::MAX_CHARS];
    logic [7:0]                    a_char_next [b64ce_pkg::MAX_CHARS];
    logic [b64ce_pkg::CNT_W-1:0]   a_nchar_reg, a_nchar_next;
    logic                          a_last_reg, a_last_next;
    logic [b64ce_pkg::IDX_W-1:0]   a_idx_reg, a_idx_next;
    logic                          sep_done_reg, sep_done_next;
    logic [b64ce_pkg::CHUNK_W-1:0] cnt_reg, cnt_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    m_char_reg, m_char_next;
    logic                          m_end_reg, m_end_next;

    // encode datapath
    logic                          accept;
    logic [b64ce_pkg::ACC_W-1:0]   acc_new;
    logic [3:0]                    bits, r1, r1m6;
    logic                          two;
    logic [2:0]                    rem;
    logic [5:0]                    c0_idx, c1_idx, tail_idx;
    logic [b64ce_pkg::ACC_W-1:0]   sh0, sh1, sht;
    logic                          has_tail;
    logic [b64ce_pkg::CNT_W-1:0]   nd, nc_pre, pads;
    logic [1:0]                    phase_sum, pad_cnt;

    // emitter control
    logic                          out_free, need_sep, step, final_char;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_char_reg;
    assign m_tlast   = m_end_reg;

    assign out_free   = !m_valid_reg || m_tready;
    assign need_sep   = (cnt_reg >= len_reg) && !sep_done_reg;
    assign step       = a_valid_reg && out_free;
    assign final_char = step && !need_sep &&
                        (b64ce_pkg::CNT_W'(a_idx_reg) ==
                         (a_nchar_reg - b64ce_pkg::CNT_W'(1)));
    assign s_tready   = !a_valid_reg || final_char;
    assign accept     = s_tvalid && s_tready;

    // split the new byte into 6-bit groups, tail and pad count
    always_comb begin
        acc_new = {acc_reg[b64ce_pkg::ACC_W-9:0], s_tdata};
        bits    = {1'b0, pend_reg} + 4'd8;
        if (bits > 4'd13) begin
            bits = 4'd13;
        end
        r1   = bits - 4'd6;
        two  = (r1 >= 4'd6);
        r1m6 = r1 - 4'd6;
        rem  = two ? r1m6[2:0] : r1[2:0];
        sh0  = acc_new >> r1;
        sh1  = acc_new >> r1m6;
        sht  = acc_new << (3'd6 - rem);
        c0_idx   = sh0[5:0];
        c1_idx   = sh1[5:0];
        tail_idx = sht[5:0];
        has_tail = s_tlast && (rem != 3'd0);
        nd        = two ? b64ce_pkg::CNT_W'(2) : b64ce_pkg::CNT_W'(1);
        nc_pre    = nd + b64ce_pkg::CNT_W'(has_tail);
        phase_sum = phase_reg + nc_pre[1:0];
        // pads bring the character count to a multiple of four
        pad_cnt   = 2'd0 - phase_sum;
        pads      = s_tlast ? b64ce_pkg::CNT_W'(pad_cnt) : '0;
    end

    // stream state and item register loading
    always_comb begin
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        phase_next   = phase_reg;
        a_nchar_next = a_nchar_reg;
        a_last_next  = a_last_reg;
        for (int i = 0; i < b64ce_pkg::MAX_CHARS; i++) begin
            a_char_next[i] = a_char_reg[i];
        end
        if (accept) begin
            acc_next     = s_tlast ? '0 : acc_new;
            pend_next    = s_tlast ? 3'd0 : rem;
            phase_next   = s_tlast ? 2'd0 : phase_sum;
            a_nchar_next = nc_pre + pads;
            a_last_next  = s_tlast;
            for (int i = 0; i < b64ce_pkg::MAX_CHARS; i++) begin
                if (b64ce_pkg::CNT_W'(i) < nd) begin
                    a_char_next[i] = b64ce_pkg::b64_char((i == 0) ? c0_idx : c1_idx);
                end else if (b64ce_pkg::CNT_W'(i) == nd && has_tail) begin
                    a_char_next[i] = b64ce_pkg::b64_char(tail_idx);
                end else begin
                    a_char_next[i] = b64ce_pkg::PAD_CHAR;
                end
            end
        end
    end

    // emitter: one separator or character per free output slot
    always_comb begin
        a_valid_next  = a_valid_reg;
        a_idx_next    = a_idx_reg;
        sep_done_next = sep_done_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        m_char_next   = m_char_reg;
        m_end_next    = m_end_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (step) begin
            m_valid_next = 1'b1;
            if (need_sep) begin
                m_char_next   = b64ce_pkg::SEP_CHAR;
                m_end_next    = 1'b0;
                cnt_next      = '0;
                sep_done_next = 1'b1;
            end else begin
                m_char_next   = a_char_reg[a_idx_reg];
                m_end_next    = final_char;
                cnt_next      = cnt_reg + b64ce_pkg::CHUNK_W'(1);
                sep_done_next = 1'b0;
                a_idx_next    = a_idx_reg + b64ce_pkg::IDX_W'(1);
                if (final_char) begin
                    a_valid_next = 1'b0;
                    a_idx_next   = '0;
                    if (a_last_reg) begin
                        cnt_next = '0;
                    end
                end
            end
        end
        if (accept) begin
            a_valid_next = 1'b1;
            a_idx_next   = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            pend_reg     <= '0;
            phase_reg    <= '0;
            len_reg      <= b64ce_pkg::CHUNK_RESET;
            a_valid_reg  <= 1'b0;
            a_idx_reg    <= '0;
            sep_done_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
            phase_reg    <= phase_next;
            if (cfg_valid && cfg_ready) begin
                len_reg <= cfg_data;
            end
            a_valid_reg  <= a_valid_next;
            a_idx_reg    <= a_idx_next;
            sep_done_reg <= sep_done_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < b64ce_pkg::MAX_CHARS; i++) begin
            a_char_reg[i] <= a_char_next[i];
        end
        a_nchar_reg <= a_nchar_next;
        a_last_reg  <= a_last_next;
        m_char_reg  <= m_char_next;
        m_end_reg   <= m_end_next;
    end

    // checks
`include "base64_chunked_encoder_core_assert.svh"

    `B64CE_ASSERT_SAME(a_sep_not_last,
        m_valid_reg && m_char_reg == b64ce_pkg::SEP_CHAR, !m_end_reg,
        "separator beat flagged as last")
    `B64CE_ASSERT_SAME(a_idx_in_range,
        a_valid_reg, b64ce_pkg::CNT_W'(a_idx_reg) < a_nchar_reg,
        "character index past item length")
    `B64CE_ASSERT_SAME(a_ready_when_empty,
        !a_valid_reg, s_tready,
        "input stalled with empty item register")
    `B64CE_ASSERT_NEXT(a_sep_then_char,
        step && need_sep, !need_sep,
        "two separators in a row")

endmodule
